// ----- rtl/core/mfqs_pkg.sv -----
`timescale 1ns / 1ps
package mfqs_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int LEVELS     = 5;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int PTR_W      = SLOT_W + 1;
  localparam int LVL_W      = $clog2(LEVELS);

  // Field widths of the channel payloads.
  localparam int F_SLOT_W  = 4;
  localparam int F_LEVEL_W = 3;

  localparam logic [PTR_W-1:0]  NIL       = PTR_W'(TASK_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TASK_SLOTS - 1);
  localparam logic [LVL_W-1:0]  LVL_LAST  = LVL_W'(LEVELS - 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCHED = 1'b1;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_WAITING = 2'd2,
    ST_BLOCKED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_POP
  } ctrl_state_t;

  typedef struct packed {
    logic wr_do;
    logic scan_init;
    logic scan_do;
    logic walk_init;
    logic walk_do;
    logic pop_do;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic unlink_needed;
    logic walk_end;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- rtl/core/mfqs_if.sv -----
`timescale 1ns / 1ps
interface sched_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [3:0] slot;
  logic       task_present;
  logic [1:0] task_status;
  logic [2:0] task_level;
  logic       task_excluded;

  modport source (output valid, operation, slot, task_present, task_status, task_level,
                  task_excluded, input ready);
  modport sink (input valid, operation, slot, task_present, task_status, task_level,
                task_excluded, output ready);
  modport monitor (input valid, ready, operation, slot, task_present, task_status,
                   task_level, task_excluded);
endinterface

interface sched_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] next_slot;
  logic [2:0] next_level;
  logic       switched;
  logic       fell_back_idle;

  modport source (output valid, next_slot, next_level, switched, fell_back_idle,
                  input ready);
  modport sink (input valid, next_slot, next_level, switched, fell_back_idle,
                output ready);
  modport monitor (input valid, ready, next_slot, next_level, switched, fell_back_idle);
endinterface

// ----- rtl/core/mfqs_ctrl.sv -----
`timescale 1ns / 1ps
module mfqs_ctrl
  import mfqs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_operation,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == OP_SCHED) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end else begin
            cmd.wr_do = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (st.unlink_needed) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else begin
          cmd.scan_do = 1'b1;
          if (st.idx_last) state_nxt = S_POP;
        end
      end
      S_WALK: begin
        cmd.walk_do = 1'b1;
        if (st.walk_end) state_nxt = st.idx_last ? S_POP : S_SCAN;
      end
      S_POP: begin
        if (!st.out_busy) begin
          cmd.pop_do = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/mfqs_dp.sv -----
`timescale 1ns / 1ps
module mfqs_dp
  import mfqs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_status_t           st,
  input  logic [3:0]           in_slot,
  input  logic                 in_task_present,
  input  logic [1:0]           in_task_status,
  input  logic [2:0]           in_task_level,
  input  logic                 in_task_excluded,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [F_SLOT_W-1:0]  out_next_slot,
  output logic [F_LEVEL_W-1:0] out_next_level,
  output logic                 out_switched,
  output logic                 out_fell_back_idle
);

  logic              present_r  [TASK_SLOTS];
  status_t           status_r   [TASK_SLOTS];
  logic [LVL_W-1:0]  level_r    [TASK_SLOTS];
  logic              excluded_r [TASK_SLOTS];
  logic              queued_r   [TASK_SLOTS];
  logic [PTR_W-1:0]  link_r     [TASK_SLOTS];
  logic [PTR_W-1:0]  head_r     [LEVELS];
  logic [PTR_W-1:0]  tail_r     [LEVELS];
  logic [SLOT_W-1:0] cur_slot_r;
  logic [SLOT_W-1:0] idx_r;
  logic [PTR_W-1:0]  prev_r, walk_r, steps_r;

  logic                 out_valid_r;
  logic [F_SLOT_W-1:0]  out_slot_r;
  logic [F_LEVEL_W-1:0] out_level_r;
  logic                 out_sw_r, out_idle_r;

  // Scan view of the slot under the index; a waiting task counts as ready.
  logic             sc_p, sc_ex, sc_q, sc_active, sc_append;
  status_t          sc_status;
  logic [LVL_W-1:0] sc_lv, app_lv;
  logic [PTR_W-1:0] idx_ptr, app_tail;

  always_comb begin
    sc_p      = present_r[idx_r];
    sc_ex     = excluded_r[idx_r];
    sc_q      = queued_r[idx_r];
    sc_status = (sc_p && status_r[idx_r] == ST_WAITING) ? ST_READY : status_r[idx_r];
    sc_active = (sc_status == ST_READY) || (sc_status == ST_RUNNING);
    sc_lv     = level_r[idx_r];
    sc_append = sc_p && !sc_ex && !sc_q && sc_active;
    app_lv    = (sc_status == ST_RUNNING && sc_lv < LVL_LAST) ? sc_lv + 1'b1 : sc_lv;
    app_tail  = tail_r[app_lv];
    idx_ptr   = {1'b0, idx_r};
  end

  // Walk step state.
  logic             wk_match;
  logic [PTR_W-1:0] wk_next;
  always_comb begin
    wk_match = (walk_r == idx_ptr);
    wk_next  = link_r[walk_r[SLOT_W-1:0]];
  end

  // Pop: first level with a non-empty queue.
  logic              pop_found;
  logic [LVL_W-1:0]  pop_lv;
  logic [PTR_W-1:0]  pop_head, pop_link;
  logic [SLOT_W-1:0] pop_slot;
  always_comb begin
    pop_found = 1'b0;
    pop_lv    = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (head_r[l] < NIL) begin
        pop_found = 1'b1;
        pop_lv    = LVL_W'(l);
      end
    end
    pop_head = head_r[pop_lv];
    pop_slot = pop_found ? pop_head[SLOT_W-1:0] : '0;
    pop_link = link_r[pop_head[SLOT_W-1:0]];
  end

  logic              wr_ok;
  logic [SLOT_W-1:0] wr_s;
  logic [LVL_W-1:0]  wr_lv;
  always_comb begin
    wr_ok = PTR_W'(in_slot) < NIL;
    wr_s  = SLOT_W'(in_slot);
    wr_lv = (32'(in_task_level) >= LEVELS) ? LVL_LAST : LVL_W'(in_task_level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        present_r[i]  <= 1'b0;
        status_r[i]   <= ST_READY;
        level_r[i]    <= '0;
        excluded_r[i] <= 1'b0;
        queued_r[i]   <= 1'b0;
      end
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= NIL;
        tail_r[l] <= NIL;
      end
      cur_slot_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.pop_do) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.wr_do && wr_ok) begin
        present_r[wr_s]  <= in_task_present;
        status_r[wr_s]   <= status_t'(in_task_status);
        excluded_r[wr_s] <= in_task_excluded;
        if (!queued_r[wr_s]) level_r[wr_s] <= wr_lv;
      end
      if (cmd.scan_do) begin
        status_r[idx_r] <= sc_append ? ST_READY : sc_status;
        if (sc_append) begin
          level_r[idx_r]  <= app_lv;
          queued_r[idx_r] <= 1'b1;
          if (head_r[app_lv] >= NIL) head_r[app_lv] <= idx_ptr;
          tail_r[app_lv] <= idx_ptr;
        end
      end
      if (cmd.walk_do && st.walk_end) begin
        queued_r[idx_r] <= 1'b0;
        if (wk_match) begin
          if (prev_r >= NIL) head_r[sc_lv] <= wk_next;
          if (tail_r[sc_lv] == walk_r) tail_r[sc_lv] <= prev_r;
        end
      end
      if (cmd.pop_do) begin
        if (pop_found) begin
          head_r[pop_lv] <= pop_link;
          if (pop_link >= NIL) tail_r[pop_lv] <= NIL;
          queued_r[pop_slot]  <= 1'b0;
          status_r[pop_slot]  <= ST_RUNNING;
        end
        cur_slot_r <= pop_slot;
      end
    end
  end

  // Link store: every entry is written before it is read.
  always_ff @(posedge clk) begin
    if (cmd.scan_do && sc_append) begin
      link_r[idx_r] <= NIL;
      if (head_r[app_lv] < NIL && app_tail < NIL) link_r[app_tail[SLOT_W-1:0]] <= idx_ptr;
    end
    if (cmd.walk_do && st.walk_end && wk_match && prev_r < NIL)
      link_r[prev_r[SLOT_W-1:0]] <= wk_next;
    if (cmd.pop_do && pop_found) link_r[pop_slot] <= NIL;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) idx_r <= SLOT_LAST;
    if (cmd.scan_do || (cmd.walk_do && st.walk_end)) idx_r <= idx_r - 1'b1;
    if (cmd.walk_init) begin
      prev_r  <= NIL;
      walk_r  <= head_r[sc_lv];
      steps_r <= '0;
    end
    if (cmd.walk_do && !st.walk_end) begin
      prev_r  <= walk_r;
      walk_r  <= wk_next;
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.pop_do) begin
      out_slot_r  <= F_SLOT_W'(pop_slot);
      out_level_r <= pop_found ? F_LEVEL_W'(pop_lv) : '0;
      out_sw_r    <= pop_slot != cur_slot_r;
      out_idle_r  <= !pop_found;
    end
  end

  always_comb begin
    st.idx_last      = (idx_r == SLOT_W'(1));
    st.unlink_needed = sc_p && !sc_ex && sc_q && !sc_active;
    st.walk_end      = (walk_r >= NIL) || wk_match || (steps_r >= NIL);
    st.out_busy      = out_valid_r && !out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_next_slot      = out_slot_r;
  assign out_next_level     = out_level_r;
  assign out_switched       = out_sw_r;
  assign out_fell_back_idle = out_idle_r;

endmodule

// ----- rtl/core/multilevel_feedback_queue_scheduler.sv -----
`timescale 1ns / 1ps
// Multilevel feedback queue scheduler. A write beat (operation 0) updates one task slot. A
// schedule beat (operation 1) scans slots from the highest down to 1 at one slot per cycle,
// except while it walks a queue of the shared link store to unlink a task that is no longer
// ready or running, then pops the head of the first non-empty level into the output
// register once that register is free or being taken. Only schedule beats produce a result.
// A new beat is taken once the previous one is finished, even while its result still waits
// in the output register.
module multilevel_feedback_queue_scheduler
  import mfqs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  sched_in_if.sink  in_ch,
  sched_out_if.source out_ch
);

  dp_cmd_t    cmd;
  dp_status_t st;

  mfqs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .st           (st),
    .cmd          (cmd)
  );

  mfqs_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_slot            (in_ch.slot),
    .in_task_present    (in_ch.task_present),
    .in_task_status     (in_ch.task_status),
    .in_task_level      (in_ch.task_level),
    .in_task_excluded   (in_ch.task_excluded),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_next_slot      (out_ch.next_slot),
    .out_next_level     (out_ch.next_level),
    .out_switched       (out_ch.switched),
    .out_fell_back_idle (out_ch.fell_back_idle)
  );

endmodule

// ----- rtl/core/mfqs_checker.sv -----
`timescale 1ns / 1ps
module mfqs_checker
  import mfqs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [F_SLOT_W-1:0]  out_next_slot,
  input logic [F_LEVEL_W-1:0] out_next_level,
  input logic                 out_switched,
  input logic                 out_fell_back_idle
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_slot)
      && $stable(out_next_level) && $stable(out_switched) && $stable(out_fell_back_idle))
    else $error("result beat changed while stalled");

  // The idle fallback always reports slot 0 from level 0.
  a_idle_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fell_back_idle |-> out_next_slot == '0 && out_next_level == '0)
    else $error("idle fallback with nonzero slot or level");

  // Slot 0 is never queued, so a popped task is a real slot on a real level.
  a_popped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fell_back_idle |->
      out_next_slot != '0 && out_next_level < F_LEVEL_W'(LEVELS))
    else $error("popped task with slot 0 or level out of range");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind multilevel_feedback_queue_scheduler mfqs_checker u_mfqs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_next_slot      (out_ch.next_slot),
  .out_next_level     (out_ch.next_level),
  .out_switched       (out_ch.switched),
  .out_fell_back_idle (out_ch.fell_back_idle)
);

// ----- test/tb_if.sv -----
`timescale 1ns / 1ps
// Shared types of the bench; the channel interfaces come with the RTL.
package tb_sched_pkg;
  typedef struct packed {
    logic [3:0] next_slot;
    logic [2:0] next_level;
    logic       switched;
    logic       fell_back_idle;
  } pick_t;
endpackage

// ----- test/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import mfqs_pkg::*;
  import tb_sched_pkg::*;

  localparam int STALL_LIMIT = 20000;

  class sched_scoreboard;
    logic       present[TASK_SLOTS];
    logic [1:0] status[TASK_SLOTS];
    int         level[TASK_SLOTS];
    logic       excluded[TASK_SLOTS];
    logic       queued[TASK_SLOTS];
    int         link[TASK_SLOTS];
    int         head[LEVELS];
    int         tail[LEVELS];
    int         current;
    pick_t      picks_due[$];
    int         errors;
    int         checked;
    int         idle_picks;

    function new();
      for (int i = 0; i < TASK_SLOTS; i++) begin
        present[i] = 0; status[i] = ST_READY; level[i] = 0; excluded[i] = 0;
        queued[i] = 0; link[i] = TASK_SLOTS;
      end
      for (int l = 0; l < LEVELS; l++) begin
        head[l] = TASK_SLOTS; tail[l] = TASK_SLOTS;
      end
      current = 0; errors = 0; checked = 0; idle_picks = 0;
    endfunction

    function void push_tail(int s, int lv);
      link[s] = TASK_SLOTS;
      if (head[lv] >= TASK_SLOTS) head[lv] = s;
      else if (tail[lv] < TASK_SLOTS) link[tail[lv]] = s;
      tail[lv] = s;
    endfunction

    function void drop_task(int s, int lv);
      int prev;
      int cur;
      prev = TASK_SLOTS;
      cur = head[lv];
      for (int n = 0; n < TASK_SLOTS && cur < TASK_SLOTS; n++) begin
        if (cur == s) begin
          if (prev >= TASK_SLOTS) head[lv] = link[cur];
          else link[prev] = link[cur];
          if (tail[lv] == cur) tail[lv] = prev;
          break;
        end
        prev = cur;
        cur = link[cur];
      end
      queued[s] = 0;
    endfunction

    function void note_beat(logic op, logic [3:0] s, logic p, logic [1:0] st,
                            logic [2:0] lv, logic ex);
      pick_t r;
      int    l;
      logic  active;
      if (op == OP_WRITE) begin
        present[s] = p; status[s] = st; excluded[s] = ex;
        if (!queued[s]) level[s] = (lv >= LEVELS) ? LEVELS - 1 : lv;
        return;
      end
      for (int i = TASK_SLOTS - 1; i >= 1; i--)
        if (present[i] && status[i] == ST_WAITING) status[i] = ST_READY;
      for (int i = TASK_SLOTS - 1; i >= 1; i--) begin
        if (!present[i] || excluded[i]) continue;
        active = (status[i] == ST_READY) || (status[i] == ST_RUNNING);
        l = level[i];
        if (!queued[i]) begin
          if (!active) continue;
          // A task that used its turn drops one level.
          if (status[i] == ST_RUNNING && l < LEVELS - 1) l++;
          level[i] = l;
          push_tail(i, l);
          status[i] = ST_READY;
          queued[i] = 1;
        end else if (!active) begin
          drop_task(i, l);
        end
      end
      r = '0;
      r.fell_back_idle = 1;
      for (int q = 0; q < LEVELS; q++) begin
        int h;
        h = head[q];
        if (h >= TASK_SLOTS) continue;
        head[q] = link[h];
        if (head[q] >= TASK_SLOTS) tail[q] = TASK_SLOTS;
        link[h] = TASK_SLOTS;
        queued[h] = 0;
        status[h] = ST_RUNNING;
        r.next_slot = 4'(h);
        r.next_level = 3'(q);
        r.fell_back_idle = 0;
        break;
      end
      r.switched = (r.next_slot != current);
      current = r.next_slot;
      picks_due.push_back(r);
    endfunction

    function void check_pick(pick_t got);
      pick_t e;
      if (picks_due.size() == 0) begin
        $error("unexpected result beat slot %0d", got.next_slot);
        errors++;
        return;
      end
      e = picks_due.pop_front();
      checked++;
      if (e.fell_back_idle) idle_picks++;
      if (got.next_slot != e.next_slot) begin
        $error("next_slot expected %0d actual %0d", e.next_slot, got.next_slot); errors++;
      end
      if (got.next_level != e.next_level) begin
        $error("next_level expected %0d actual %0d", e.next_level, got.next_level); errors++;
      end
      if (got.switched != e.switched) begin
        $error("switched expected %0d actual %0d", e.switched, got.switched); errors++;
      end
      if (got.fell_back_idle != e.fell_back_idle) begin
        $error("fell_back_idle expected %0d actual %0d", e.fell_back_idle,
               got.fell_back_idle);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  always #4 clk = ~clk;

  sched_in_if  in_ch();
  sched_out_if out_ch();

  multilevel_feedback_queue_scheduler dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  sched_scoreboard sb = new();
  int  stall_cycles = 0;
  bit  rx_on = 0;
  int  sent = 0;

  initial begin
    in_ch.valid = 0; in_ch.operation = OP_WRITE; in_ch.slot = 0; in_ch.task_present = 0;
    in_ch.task_status = 0; in_ch.task_level = 0; in_ch.task_excluded = 0;
    out_ch.ready = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: checks accepted beats and toggles ready with random stalls.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_pick({out_ch.next_slot, out_ch.next_level, out_ch.switched,
                     out_ch.fell_back_idle});
    if (rst_n && (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    int g;
    @(posedge clk);
    while (!rx_on) @(posedge clk);
    forever begin
      g = gap_len();
      if (g == 0) begin
        out_ch.ready <= 1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    @(posedge clk);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  task automatic send_beat(logic op, logic [3:0] s, logic p, logic [1:0] st, logic [2:0] lv,
                           logic ex);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.operation <= op; in_ch.slot <= s; in_ch.task_present <= p;
    in_ch.task_status <= st; in_ch.task_level <= lv; in_ch.task_excluded <= ex;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_beat(op, s, p, st, lv, ex);
    sent++;
  endtask

  task automatic write_slot(logic [3:0] s, logic p, logic [1:0] st, logic [2:0] lv, logic ex);
    send_beat(OP_WRITE, s, p, st, lv, ex);
  endtask

  task automatic schedule();
    send_beat(OP_SCHED, 4'($urandom), 1'($urandom), 2'($urandom), 3'($urandom),
              1'($urandom));
  endtask

  initial begin
    int r;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    rx_on = 1;
    @(posedge clk);

    // Directed: idle fallback, slot extremes, every status, level saturation.
    schedule();
    write_slot(4'd15, 1, ST_READY, 3'd0, 0);
    write_slot(4'd1, 1, ST_RUNNING, 3'd7, 0);
    write_slot(4'd2, 1, ST_WAITING, 3'd4, 0);
    write_slot(4'd3, 1, ST_BLOCKED, 3'd2, 0);
    write_slot(4'd0, 1, ST_READY, 3'd0, 0);
    write_slot(4'd5, 1, ST_READY, 3'd1, 1);
    schedule();
    // Level write while queued is dropped; blocked queued task gets unlinked.
    write_slot(4'd2, 1, ST_READY, 3'd0, 0);
    write_slot(4'd1, 1, ST_BLOCKED, 3'd0, 0);
    schedule();
    // Queued task made absent can still be popped; an excluded task is not queued again.
    write_slot(4'd2, 0, ST_READY, 3'd0, 0);
    write_slot(4'd15, 1, ST_READY, 3'd3, 1);
    schedule();
    schedule();
    schedule();
    schedule();
    write_slot(4'd6, 1, ST_RUNNING, 3'd4, 0);
    schedule();
    schedule();

    // Random: mostly present, schedulable tasks, with a schedule every few beats.
    for (int i = 0; i < 1830; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) schedule();
      else if (r < 85)
        write_slot(4'($urandom), 1'b1, 2'($urandom_range(0, 2)), 3'($urandom_range(0, 4)),
                   ($urandom_range(0, 9) == 0));
      else
        write_slot(4'($urandom), 1'($urandom), 2'($urandom), 3'($urandom), 1'($urandom));
    end
    in_ch.valid <= 0;

    while (sb.picks_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d beats, checked %0d schedule decisions (%0d idle fallbacks).",
             sent, sb.checked, sb.idle_picks);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/mfqs_pkg.sv
rtl/core/mfqs_if.sv
rtl/core/mfqs_ctrl.sv
rtl/core/mfqs_dp.sv
rtl/core/multilevel_feedback_queue_scheduler.sv
rtl/core/mfqs_checker.sv
test/tb_if.sv
test/tb.sv
